/* src/imupcf_pkg.sv */
// Shared types, register indexes and the CORDIC angle table for the pitch filter.
`default_nettype none

package imupcf_pkg;

    localparam logic [1:0] REG_GYRO_BIAS    = 2'd0;
    localparam logic [1:0] REG_GYRO_SENS    = 2'd1;
    localparam logic [1:0] REG_BLEND_WEIGHT = 2'd2;
    localparam logic [1:0] REG_TICK_PERIOD  = 2'd3;

    typedef struct packed {
        logic       load;
        logic       mul1;
        logic       mul2;
        logic       mul3;
        logic       div_step;
        logic       sqrt_step;
        logic       sqrt_last;
        logic       cordic_step;
        logic [4:0] step_idx;
        logic       acc;
        logic       blend;
        logic       sum;
        logic       publish;
    } imupcf_cmd_t;

    // atan(2^-i) in Q24 degrees
    function automatic logic [31:0] atan_q24(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'd754974720;
            5'd1:    v = 32'd445687602;
            5'd2:    v = 32'd235489088;
            5'd3:    v = 32'd119537938;
            5'd4:    v = 32'd60000934;
            5'd5:    v = 32'd30029717;
            5'd6:    v = 32'd15018523;
            5'd7:    v = 32'd7509720;
            5'd8:    v = 32'd3754917;
            5'd9:    v = 32'd1877466;
            5'd10:   v = 32'd938734;
            5'd11:   v = 32'd469367;
            5'd12:   v = 32'd234684;
            5'd13:   v = 32'd117342;
            5'd14:   v = 32'd58671;
            5'd15:   v = 32'd29335;
            5'd16:   v = 32'd14668;
            5'd17:   v = 32'd7334;
            5'd18:   v = 32'd3667;
            5'd19:   v = 32'd1833;
            5'd20:   v = 32'd917;
            5'd21:   v = 32'd458;
            5'd22:   v = 32'd229;
            5'd23:   v = 32'd115;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* src/imupcf_ctrl.sv */
// Sequencer for the pitch filter: steps the datapath through one sample.
`default_nettype none

module imupcf_ctrl
    import imupcf_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 16,
    parameter int CORDIC_STEPS    = 18
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  wire         m_tready,
    output imupcf_cmd_t cmd
);

    localparam int DW   = 49 + ANGLE_FRAC_BITS;
    localparam int CNTW = $clog2(DW);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_MUL1  = 9'b000000010,
        ST_MUL2  = 9'b000000100,
        ST_MUL3  = 9'b000001000,
        ST_ITER  = 9'b000010000,
        ST_ACC   = 9'b000100000,
        ST_BLEND = 9'b001000000,
        ST_SUM   = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNTW-1:0]   cnt_reg, cnt_next;
    logic              mvalid_reg, mvalid_next;
    logic [CNTW-1:0]   cordic_cnt;

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = mvalid_reg;
    assign cordic_cnt = cnt_reg - CNTW'(32);

    always_comb
    begin
        cmd             = '0;
        cmd.load        = s_tvalid && (state_reg == ST_IDLE);
        cmd.mul1        = (state_reg == ST_MUL1);
        cmd.mul2        = (state_reg == ST_MUL2);
        cmd.mul3        = (state_reg == ST_MUL3);
        cmd.div_step    = (state_reg == ST_ITER);
        cmd.sqrt_step   = (state_reg == ST_ITER) && (cnt_reg < CNTW'(32));
        cmd.sqrt_last   = (state_reg == ST_ITER) && (cnt_reg == CNTW'(31));
        cmd.cordic_step = (state_reg == ST_ITER) && (cnt_reg >= CNTW'(32))
                          && (cnt_reg < CNTW'(32 + CORDIC_STEPS));
        cmd.step_idx    = (cnt_reg < CNTW'(32)) ? cnt_reg[4:0] : cordic_cnt[4:0];
        cmd.acc         = (state_reg == ST_ACC);
        cmd.blend       = (state_reg == ST_BLEND);
        cmd.sum         = (state_reg == ST_SUM);
        cmd.publish     = (state_reg == ST_OUT) && (!mvalid_reg || m_tready);
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        mvalid_next = mvalid_reg;
        if (mvalid_reg && m_tready)
        begin
            mvalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:  state_next = ST_MUL2;
            ST_MUL2:  state_next = ST_MUL3;
            ST_MUL3:
            begin
                cnt_next   = '0;
                state_next = ST_ITER;
            end
            ST_ITER:
            begin
                cnt_next = cnt_reg + CNTW'(1);
                if (cnt_reg == CNTW'(DW - 1))
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:   state_next = ST_BLEND;
            ST_BLEND: state_next = ST_SUM;
            ST_SUM:   state_next = ST_OUT;
            ST_OUT:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    mvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            mvalid_reg <= mvalid_next;
        end
    end

`ifndef SYNTH
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_MUL1))
        else $error("input transfer did not start a sample");
    a_publish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |=> m_tvalid)
        else $error("published result not valid");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ITER) |-> (cnt_reg <= CNTW'(DW - 1)))
        else $error("iteration counter out of range");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !cmd.publish)
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

/* src/imupcf_dp.sv */
// Datapath: config registers, products, square root, CORDIC, divider and blend.
`default_nettype none

module imupcf_dp
    import imupcf_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 16
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire  [1:0]  cfg_index,
    input  wire  [15:0] cfg_data,
    input  wire  [79:0] s_tdata,
    input  imupcf_cmd_t cmd,
    output logic [55:0] m_tdata
);

    localparam int F   = ANGLE_FRAC_BITS;
    localparam int DW  = 49 + F;
    localparam int QW  = F + 30;
    localparam int GW  = F + 32;
    localparam int CW  = F + 27;
    localparam int AW  = F + 8;
    localparam int PW  = F + 9;
    localparam int HW  = F + 11;
    localparam int THW = F + 28;
    localparam int TLW = F + 28;
    localparam int PSW = F + 29;
    localparam int S   = 24 - F;

    localparam logic signed [33:0]  RND     = 34'((64'd1 << S) >> 1);
    localparam logic signed [33:0]  NINE34  = 34'(64'd90 << F);
    localparam logic signed [AW-1:0] NINETY = AW'(64'd90 << F);
    localparam logic signed [GW-1:0] GLIM   = GW'(64'd1 << (25 + F));
    localparam logic signed [PSW-1:0] PHI   = PSW'((64'd256 << F) - 64'd1);
    localparam logic signed [PSW-1:0] PLO   = -PHI - PSW'(1);

    // configuration
    logic signed [15:0] bias_reg;
    logic        [7:0]  sens_reg;
    logic        [15:0] weight_reg;
    logic        [15:0] period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg   <= '0;
            sens_reg   <= 8'd131;
            weight_reg <= 16'd62915;
            period_reg <= 16'd2000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GYRO_BIAS:    bias_reg   <= $signed(cfg_data);
                REG_GYRO_SENS:    sens_reg   <= cfg_data[7:0];
                REG_BLEND_WEIGHT: weight_reg <= cfg_data;
                REG_TICK_PERIOD:  period_reg <= cfg_data;
                default:          bias_reg   <= bias_reg;
            endcase
        end
    end

    // sample and working registers
    logic signed [16:0]    x_reg, y_reg, z_reg;
    logic signed [15:0]    g_reg;
    logic        [15:0]    ticks_reg;
    logic        [33:0]    ysq_reg, zsq_reg;
    logic        [31:0]    mag1_reg;
    logic        [47:0]    mag2_reg;
    logic                  neg_reg;
    logic        [27:0]    d_reg;
    logic        [63:0]    sqn_reg, sqres_reg;
    logic        [DW-1:0]  dvd_reg;
    logic        [27:0]    rem_reg;
    logic signed [35:0]    xv_reg, yv_reg;
    logic signed [32:0]    ang_reg;
    logic signed [AW-1:0]  acc_reg;
    logic signed [CW-1:0]  gyc_reg;
    logic signed [THW-1:0] thi_reg;
    logic signed [TLW-1:0] tlo_reg;
    logic signed [PW-1:0]  last_reg;
    logic                  sat_reg;
    logic        [55:0]    mdata_reg;

    // combinational helpers
    logic signed [16:0]    gdiff;
    logic        [15:0]    gmag;
    logic        [7:0]     sens_eff;
    logic        [63:0]    sq_bit, sq_trial, sqn_next, sqres_next;
    logic        [28:0]    div_r2;
    logic                  div_ge;
    logic signed [35:0]    dx, dy;
    logic signed [32:0]    atan_v;
    logic signed [33:0]    ang_rnd;
    logic signed [AW-1:0]  acc_cordic, acc_sel;
    logic signed [GW-1:0]  delta, gy;
    logic signed [HW-1:0]  gh;
    logic signed [17:0]    b_s;
    logic signed [16:0]    a_s;
    logic signed [PSW-1:0] psum;
    logic signed [PW+24:0] pitch_ext;
    logic signed [AW+23:0] acc_ext;

    assign gdiff    = 17'(g_reg) - 17'(bias_reg);
    assign gmag     = gdiff[16] ? 16'(-gdiff) : gdiff[15:0];
    assign sens_eff = (sens_reg == 8'd0) ? 8'd1 : sens_reg;

    assign sq_bit     = 64'd1 << {5'd31 - cmd.step_idx, 1'b0};
    assign sq_trial   = sqres_reg + sq_bit;
    assign sqn_next   = (sqn_reg >= sq_trial) ? sqn_reg - sq_trial : sqn_reg;
    assign sqres_next = (sqn_reg >= sq_trial) ? (sqres_reg >> 1) + sq_bit
                                              : (sqres_reg >> 1);

    assign div_r2 = {rem_reg, dvd_reg[DW-1]};
    assign div_ge = (div_r2 >= {1'b0, d_reg});

    assign dx     = yv_reg >>> cmd.step_idx;
    assign dy     = xv_reg >>> cmd.step_idx;
    assign atan_v = $signed({1'b0, atan_q24(cmd.step_idx)});

    always_comb
    begin
        ang_rnd = (34'(ang_reg) + RND) >>> S;
        if (ang_rnd > NINE34)
        begin
            ang_rnd = NINE34;
        end
        else if (ang_rnd < -NINE34)
        begin
            ang_rnd = -NINE34;
        end
        acc_cordic = AW'(ang_rnd);
        // y and z both zero: straight up or down by the sign of x, level if x is zero too
        if (y_reg == 17'sd0 && z_reg == 17'sd0)
        begin
            if (x_reg > 17'sd0)
            begin
                acc_sel = NINETY;
            end
            else if (x_reg < 17'sd0)
            begin
                acc_sel = -NINETY;
            end
            else
            begin
                acc_sel = '0;
            end
        end
        else
        begin
            acc_sel = acc_cordic;
        end
    end

    always_comb
    begin
        delta = $signed(GW'(dvd_reg[QW-1:0]));
        if (neg_reg)
        begin
            delta = -delta;
        end
        gy = GW'(last_reg) + delta;
        if (gy > GLIM)
        begin
            gy = GLIM;
        end
        else if (gy < -GLIM)
        begin
            gy = -GLIM;
        end
    end

    assign gh  = HW'(gyc_reg >>> 16);
    assign a_s = $signed({1'b0, weight_reg});
    assign b_s = $signed(18'(32'd65536 - 32'(weight_reg)));

    always_comb
    begin
        psum = PSW'(thi_reg) + PSW'((tlo_reg + TLW'(32768)) >>> 16);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg     <= -17'($signed(s_tdata[15:0]));
            y_reg     <= -17'($signed(s_tdata[31:16]));
            z_reg     <= 17'($signed(s_tdata[47:32]));
            g_reg     <= $signed(s_tdata[63:48]);
            ticks_reg <= s_tdata[79:64];
        end
        if (cmd.mul1)
        begin
            ysq_reg  <= 34'(y_reg * y_reg);
            zsq_reg  <= 34'(z_reg * z_reg);
            mag1_reg <= 32'(gmag) * 32'(ticks_reg);
            neg_reg  <= gdiff[16];
            d_reg    <= 28'(sens_eff) * 28'd1000000;
        end
        if (cmd.mul2)
        begin
            sqn_reg   <= 64'(ysq_reg + zsq_reg) << 28;
            sqres_reg <= '0;
            mag2_reg  <= 48'(mag1_reg) * 48'(period_reg);
        end
        if (cmd.mul3)
        begin
            dvd_reg <= (DW'(mag2_reg) << F) + DW'(d_reg >> 1);
            rem_reg <= '0;
            yv_reg  <= 36'(x_reg) <<< 14;
            ang_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= div_ge ? 28'(div_r2 - {1'b0, d_reg}) : div_r2[27:0];
            dvd_reg <= {dvd_reg[DW-2:0], div_ge};
        end
        if (cmd.sqrt_step)
        begin
            sqn_reg   <= sqn_next;
            sqres_reg <= sqres_next;
        end
        if (cmd.sqrt_last)
        begin
            xv_reg <= $signed(36'(sqres_next));
        end
        if (cmd.cordic_step)
        begin
            if (yv_reg >= 36'sd0)
            begin
                xv_reg  <= xv_reg + dx;
                yv_reg  <= yv_reg - dy;
                ang_reg <= ang_reg + atan_v;
            end
            else
            begin
                xv_reg  <= xv_reg - dx;
                yv_reg  <= yv_reg + dy;
                ang_reg <= ang_reg - atan_v;
            end
        end
        if (cmd.acc)
        begin
            acc_reg <= acc_sel;
            gyc_reg <= CW'(gy);
        end
        if (cmd.blend)
        begin
            thi_reg <= THW'(a_s) * THW'(gh);
            tlo_reg <= TLW'(a_s) * TLW'($signed({1'b0, gyc_reg[15:0]}))
                       + TLW'(b_s) * TLW'(acc_reg);
        end
        if (cmd.publish)
        begin
            mdata_reg <= {6'd0, sat_reg, acc_ext[23:0], pitch_ext[24:0]};
        end
    end

    // last pitch is filter state and clears on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= '0;
            sat_reg  <= 1'b0;
        end
        else if (cmd.sum)
        begin
            if (psum > PHI)
            begin
                last_reg <= PW'(PHI);
                sat_reg  <= 1'b1;
            end
            else if (psum < PLO)
            begin
                last_reg <= PW'(PLO);
                sat_reg  <= 1'b1;
            end
            else
            begin
                last_reg <= PW'(psum);
                sat_reg  <= 1'b0;
            end
        end
    end

    assign pitch_ext = (PW + 25)'(last_reg);
    assign acc_ext   = (AW + 24)'(acc_reg);
    assign m_tdata   = mdata_reg;

endmodule

`default_nettype wire

/* src/imu_pitch_complementary_filter.sv */
// Top level of the IMU pitch complementary filter: controller plus datapath.
//
// channel  dir  signals                     contents
// s_*      in   s_tvalid s_tready s_tdata    one IMU sample per transfer
// m_*      out  m_tvalid m_tready m_tdata    fused pitch, accel pitch, clip flag
// cfg_*    in   cfg_we cfg_index cfg_data    register writes, no read-back
//
// Each sample is paced by the restoring divider for the gyro increment, one quotient bit
// a cycle; square root and CORDIC run alongside it. s_tready stays low until the result
// of the sample is handed to the output register.
// The result sits in an output register; while it waits on m_tready the next sample is
// taken and computed, then held until the output register frees.
// Reset clears the last pitch and restores register defaults.
`default_nettype none

module imu_pitch_complementary_filter
    import imupcf_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 16,
    parameter int CORDIC_STEPS    = 18
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    // accel_x_raw[15:0], accel_y_raw[31:16], accel_z_raw[47:32],
    // gyro_y_raw[63:48], elapsed_ticks[79:64]
    input  wire  [79:0] s_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    // pitch_deg[24:0], accel_angle_deg[48:25], saturated[49], zero[55:50]
    output logic [55:0] m_tdata,
    input  wire         cfg_we,
    input  wire  [1:0]  cfg_index,
    input  wire  [15:0] cfg_data
);

    imupcf_cmd_t cmd;

    imupcf_ctrl #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .CORDIC_STEPS    (CORDIC_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    imupcf_dp #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire
